// ===== rtl/obc_pkg.sv =====
// Shared constants, threshold tables and types for the orbit binning and
// classification pipeline. No dependencies.
package obc_pkg;

  localparam int Q_BINS = 29;
  localparam int E_BINS = 8;
  localparam int I_BINS = 11;
  localparam int H_BINS = 18;

  localparam int Q_W = 23;
  localparam int E_W = 17;
  localparam int I_W = 16;
  localparam int H_W = 16;

  // Registers from the input ports to the results of the arithmetic units.
  localparam int ARITH_LAT = 19;
  // Combine stages after the units, the last one being the output register.
  localparam int PIPE_LAT  = ARITH_LAT + 3;

  localparam logic [Q_W-1:0] Q_THR [Q_BINS] = '{
    23'd26214, 23'd45875, 23'd52429, 23'd58982, 23'd65536, 23'd72090, 23'd78643,
    23'd85197, 23'd91750, 23'd98304, 23'd109445, 23'd117965, 23'd131072,
    23'd144179, 23'd157286, 23'd170394, 23'd183501, 23'd196608, 23'd209715,
    23'd229376, 23'd262144, 23'd294912, 23'd327680, 23'd360448, 23'd655360,
    23'd1310720, 23'd1966080, 23'd2621440, 23'd6553600
  };
  localparam logic [E_W-1:0] E_THR [E_BINS] = '{
    17'd6554, 17'd13107, 17'd19661, 17'd26214, 17'd32768, 17'd45875, 17'd58982,
    17'd72090
  };
  localparam logic [I_W-1:0] I_THR [I_BINS] = '{
    16'd512, 16'd1280, 16'd2560, 16'd3840, 16'd5120, 16'd6400, 16'd7680,
    16'd10240, 16'd15360, 16'd23040, 16'd46080
  };
  localparam logic signed [H_W-1:0] H_THR [H_BINS] = '{
    16'sd1536, 16'sd2048, 16'sd2560, 16'sd2816, 16'sd3072, 16'sd3328, 16'sd3584,
    16'sd3840, 16'sd4096, 16'sd4352, 16'sd4608, 16'sd4864, 16'sd5120, 16'sd5376,
    16'sd5632, 16'sd5888, 16'sd6144, 16'sd6528
  };

  // Semi-major axis windows, lower and upper bound, Q16 AU.
  localparam int AB_N = 8;
  localparam int AB_HUN = 0;
  localparam int AB_PHO = 1;
  localparam int AB_INB = 2;
  localparam int AB_PAL = 3;
  localparam int AB_HAN = 4;
  localparam int AB_OUT = 5;
  localparam int AB_HIL = 6;
  localparam int AB_TRO = 7;
  localparam logic [18:0] AB_LO [AB_N] = '{
    19'd116654, 19'd144179, 19'd137626, 19'd163840, 19'd167117, 19'd183501,
    19'd255590, 19'd330957
  };
  localparam logic [18:0] AB_HI [AB_N] = '{
    19'd131072, 19'd160563, 19'd163840, 19'd183501, 19'd178258, 19'd212992,
    19'd263455, 19'd350618
  };

  localparam logic [Q_W-1:0] Q_NEO     = 23'd85197;
  localparam logic [Q_W-1:0] Q_MARS    = 23'd109445;
  localparam logic [Q_W-1:0] Q_PHO     = 23'd98304;
  localparam logic [E_W-1:0] E_ONE     = 17'd65536;
  localparam logic [E_W-1:0] E_INT     = 17'd32768;
  localparam logic [E_W-1:0] E_HUN     = 17'd11796;
  localparam logic [E_W-1:0] E_PAL     = 17'd22938;
  localparam logic [E_W-1:0] E_HAN     = 17'd16384;
  localparam logic [E_W-1:0] E_MID     = 17'd29491;
  localparam logic [E_W-1:0] E_OUT     = 17'd26214;
  localparam logic [E_W-1:0] E_TRO     = 17'd14418;
  localparam logic [I_W-1:0] I_INT     = 16'd10240;
  localparam logic [I_W-1:0] I_HUN_LO  = 16'd4096;
  localparam logic [I_W-1:0] I_HUN_HI  = 16'd8704;
  localparam logic [I_W-1:0] I_PHO_LO  = 16'd5120;
  localparam logic [I_W-1:0] I_PHO_HI  = 16'd6912;
  localparam logic [I_W-1:0] I_PAL_LO  = 16'd6144;
  localparam logic [I_W-1:0] I_PAL_HI  = 16'd9472;
  localparam logic [I_W-1:0] I_HAN_LO  = 16'd5120;
  localparam logic [I_W-1:0] I_HAN_HI  = 16'd6016;
  localparam logic [I_W-1:0] I_MID     = 16'd5120;
  localparam logic [I_W-1:0] I_HIL     = 16'd4608;
  localparam logic [I_W-1:0] I_TRO     = 16'd9728;
  localparam logic signed [H_W-1:0] H_NEO_LO = 16'sd5760;
  localparam logic signed [H_W-1:0] H_NEO_HI = 16'sd4736;
  localparam logic [19:0] APH_INT  = 20'd655360;
  localparam logic [19:0] APH_MARS = 20'd103547;
  localparam logic [13:0] INB_OFS  = 14'd11648;
  localparam logic [12:0] INB_Q    = 13'd6400;
  localparam logic [3:0]  OUT_SLP  = 4'd9;
  localparam logic [17:0] OUT_OFS  = 18'd183296;
  localparam logic [16:0] OUT_Q    = 17'd81920;

  // Tisserand term constants.
  localparam logic [18:0] JFC_K1  = 19'd340787;
  localparam logic [13:0] SQ_K    = 14'd12603;
  localparam logic [24:0] T_LO    = 25'd131072;
  localparam logic [24:0] T_HI    = 25'd196608;

  // Cosine: angle folding and Horner steps in Q30.
  localparam logic [16:0] ANG_360 = 17'd92160;
  localparam logic [16:0] ANG_180 = 17'd46080;
  localparam logic [16:0] ANG_90  = 17'd23040;
  localparam logic [16:0] DEG2RAD = 17'd73204;
  localparam logic [30:0] COS_ONE = 31'h4000_0000;
  localparam int COS_STEPS = 5;
  localparam logic [6:0] COS_DIV [COS_STEPS] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
  localparam logic [31:0] COS_REC [COS_STEPS] = '{
    32'((64'd1 << 32) / 64'd90), 32'((64'd1 << 32) / 64'd56),
    32'((64'd1 << 32) / 64'd30), 32'((64'd1 << 32) / 64'd12),
    32'((64'd1 << 32) / 64'd2)
  };

  typedef struct packed {
    logic        in_model;
    logic [4:0]  q_bin;
    logic [2:0]  e_bin;
    logic [3:0]  i_bin;
    logic [4:0]  h_bin;
    logic [13:0] mask;
    logic        jfc_q_ok;
    logic        d_neg;
    logic [16:0] ad;
  } side_t;

endpackage

// ===== rtl/obc_classify.sv =====
// Threshold binning and the fourteen closed-form class tests, two stages
// plus a delay line to line up with the arithmetic units. Uses obc_pkg.
module obc_classify (
  input  logic                           clk,
  input  logic                           en,
  input  logic [obc_pkg::Q_W-1:0]        q,
  input  logic [obc_pkg::E_W-1:0]        e,
  input  logic [obc_pkg::I_W-1:0]        i,
  input  logic signed [obc_pkg::H_W-1:0] h,
  output obc_pkg::side_t                 side
);
  import obc_pkg::*;

  localparam int PAD = ARITH_LAT - 1;

  logic [Q_BINS-1:0]  qt_nxt, qt_r;
  logic [E_BINS-1:0]  et_nxt, et_r;
  logic [I_BINS-1:0]  it_nxt, it_r;
  logic [H_BINS-2:0]  ht_nxt, ht_r;
  logic [E_W-1:0]     d_nxt, d_r;
  logic [16:0]        ad_nxt;
  logic [40:0]        pqe_r;
  logic [32:0]        id_r;
  logic [Q_W-1:0]     q_r;
  logic [E_W-1:0]     e_r;
  logic [I_W-1:0]     i_r;
  logic signed [H_W-1:0] h_r;
  logic               qok_r, dneg_r;
  logic [16:0]        ad_r;
  side_t              side_nxt;
  side_t              pad_r [PAD];

  always_comb begin
    for (int k = 0; k < Q_BINS; k++) qt_nxt[k] = (q >= Q_THR[k]);
    for (int k = 0; k < E_BINS; k++) et_nxt[k] = (e >= E_THR[k]);
    for (int k = 0; k < I_BINS; k++) it_nxt[k] = (i >= I_THR[k]);
    for (int k = 0; k < H_BINS - 1; k++) ht_nxt[k] = (h >= H_THR[k]);
    d_nxt  = e[16] ? '0 : E_ONE - e;
    ad_nxt = (e > E_ONE) ? e - E_ONE : E_ONE - e;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qt_r   <= qt_nxt;
      et_r   <= et_nxt;
      it_r   <= it_nxt;
      ht_r   <= ht_nxt;
      d_r    <= d_nxt;
      pqe_r  <= 41'(q) * 41'(18'(e) + 18'(E_ONE));
      id_r   <= 33'(i) * 33'(d_nxt);
      q_r    <= q;
      e_r    <= e;
      i_r    <= i;
      h_r    <= h;
      qok_r  <= (q >= Q_NEO);
      dneg_r <= (e > E_ONE);
      ad_r   <= ad_nxt;
    end
  end

  logic [4:0]  qb, hb;
  logic [3:0]  eb, ib;
  logic        inm, e_lt1, neo;
  logic [AB_N-1:0] ab;
  logic        aph_int, aph_mars, belt_in, belt_out;
  logic [38:0] qs;
  logic [13:0] m;

  always_comb begin
    qb = '0;
    eb = '0;
    ib = '0;
    hb = '0;
    // thermometer codes: the bin is the count of thresholds passed
    for (int k = 0; k < Q_BINS; k++) if (qt_r[k]) qb = 5'(k + 1);
    for (int k = 0; k < E_BINS; k++) if (et_r[k]) eb = 4'(k + 1);
    for (int k = 0; k < I_BINS; k++) if (it_r[k]) ib = 4'(k + 1);
    for (int k = 0; k < H_BINS - 1; k++) if (ht_r[k]) hb = 5'(k + 1);
    inm = !qt_r[Q_BINS-1] && !et_r[E_BINS-1] && !it_r[I_BINS-1];

    e_lt1 = !e_r[16];
    qs    = {q_r, 16'h0000};
    for (int p = 0; p < AB_N; p++) begin
      ab[p] = e_lt1 && (qs > 39'(39'(AB_LO[p]) * 39'(d_r)))
                    && (qs < 39'(39'(AB_HI[p]) * 39'(d_r)));
    end
    aph_int  = e_r[16] || (pqe_r > 41'(41'(APH_INT) * 41'(d_r)));
    aph_mars = e_r[16] || (pqe_r > 41'(41'(APH_MARS) * 41'(d_r)));
    belt_in  = (41'(id_r) + 41'(41'(INB_OFS) * 41'(d_r))) < 41'(41'(INB_Q) * 41'(q_r));
    belt_out = (41'(41'(OUT_SLP) * 41'(id_r)) + 41'(41'(OUT_OFS) * 41'(d_r)))
               < 41'(41'(OUT_Q) * 41'(q_r));
    neo = (q_r < Q_NEO);

    m[0]  = neo || (e_r >= E_INT) || (i_r >= I_INT) || aph_int;
    m[1]  = neo;
    m[2]  = neo && (h_r < H_NEO_LO);
    m[3]  = neo && (h_r < H_NEO_HI);
    m[4]  = !neo && (q_r < Q_MARS) && aph_mars;
    m[5]  = !(e_r > E_HUN || i_r < I_HUN_LO || i_r > I_HUN_HI) && ab[AB_HUN];
    m[6]  = !(q_r < Q_PHO || i_r < I_PHO_LO || i_r > I_PHO_HI) && ab[AB_PHO];
    m[7]  = (q_r >= Q_MARS) && ab[AB_INB] && belt_in;
    m[8]  = !(e_r > E_PAL || i_r < I_PAL_LO || i_r > I_PAL_HI) && ab[AB_PAL];
    m[9]  = !(e_r > E_HAN || i_r < I_HAN_LO || i_r > I_HAN_HI) && ab[AB_HAN];
    m[10] = !(e_r > E_MID || i_r > I_MID) && ab[AB_PAL];
    m[11] = !(e_r > E_OUT) && ab[AB_OUT] && belt_out;
    m[12] = !(i_r > I_HIL || e_r > E_OUT) && ab[AB_HIL];
    m[13] = !(e_r > E_TRO || i_r > I_TRO) && ab[AB_TRO];

    side_nxt.in_model = inm;
    side_nxt.q_bin    = inm ? qb : '0;
    side_nxt.e_bin    = inm ? eb[2:0] : '0;
    side_nxt.i_bin    = inm ? ib : '0;
    side_nxt.h_bin    = inm ? hb : '0;
    side_nxt.mask     = m;
    side_nxt.jfc_q_ok = qok_r;
    side_nxt.d_neg    = dneg_r;
    side_nxt.ad       = ad_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pad_r[0] <= side_nxt;
      for (int j = 1; j < PAD; j++) pad_r[j] <= pad_r[j-1];
    end
  end

  assign side = pad_r[PAD-1];

endmodule

// ===== rtl/obc_recip.sv =====
// Pipelined restoring divider for floor(2^32 / q), two quotient bits per
// stage, padded to the common unit latency. Uses obc_pkg.
module obc_recip (
  input  logic                    clk,
  input  logic                    en,
  input  logic [obc_pkg::Q_W-1:0] den,
  output logic [15:0]             quo
);
  import obc_pkg::*;

  localparam int STG = 8;
  localparam int PAD = ARITH_LAT - STG;

  typedef struct packed {
    logic [22:0] rem;
    logic [15:0] quo;
    logic [22:0] den;
  } rcp_t;

  function automatic rcp_t rcp_step(rcp_t s);
    logic [23:0] cur;
    rcp_t        o;
    o   = s;
    cur = {s.rem, 1'b0};
    if (cur >= {1'b0, s.den}) begin
      o.rem = 23'(cur - {1'b0, s.den});
      o.quo = {s.quo[14:0], 1'b1};
    end else begin
      o.rem = cur[22:0];
      o.quo = {s.quo[14:0], 1'b0};
    end
    return o;
  endfunction

  rcp_t        seed;
  rcp_t        st_r  [STG];
  logic [15:0] pad_r [PAD];

  // the upper half of 2^32 is the starting remainder; q is above it in range
  assign seed = '{rem: 23'd65536, quo: '0, den: den};

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= rcp_step(rcp_step(seed));
      for (int j = 1; j < STG; j++) st_r[j] <= rcp_step(rcp_step(st_r[j-1]));
      pad_r[0] <= st_r[STG-1].quo;
      for (int j = 1; j < PAD; j++) pad_r[j] <= pad_r[j-1];
    end
  end

  assign quo = pad_r[PAD-1];

endmodule

// ===== rtl/obc_isqrt.sv =====
// Forms q(1+e)/5.2 and takes its integer square root, two root bits per
// stage, padded to the common unit latency. Uses obc_pkg.
module obc_isqrt (
  input  logic                    clk,
  input  logic                    en,
  input  logic [obc_pkg::Q_W-1:0] q,
  input  logic [obc_pkg::E_W-1:0] e,
  output logic [19:0]             root
);
  import obc_pkg::*;

  localparam int STG = 10;
  localparam int PAD = ARITH_LAT - STG - 2;

  typedef struct packed {
    logic [21:0] rem;
    logic [19:0] root;
    logic [39:0] xs;
  } sq_t;

  function automatic sq_t sq_step(sq_t s);
    logic [23:0] cur;
    logic [23:0] trial;
    sq_t         o;
    cur   = {s.rem, s.xs[39:38]};
    trial = {2'b00, s.root, 2'b01};
    o.xs  = {s.xs[37:0], 2'b00};
    if (cur >= trial) begin
      o.rem  = 22'(cur - trial);
      o.root = {s.root[18:0], 1'b1};
    end else begin
      o.rem  = cur[21:0];
      o.root = {s.root[18:0], 1'b0};
    end
    return o;
  endfunction

  logic [40:0] pq_r;
  logic [54:0] px;
  logic [38:0] x_r;
  sq_t         seed;
  sq_t         st_r  [STG];
  logic [19:0] pad_r [PAD];

  assign px   = 55'(pq_r) * 55'(SQ_K);
  assign seed = '{rem: '0, root: '0, xs: {1'b0, x_r}};

  always_ff @(posedge clk) begin
    if (en) begin
      pq_r    <= 41'(q) * 41'(18'(e) + 18'(E_ONE));
      x_r     <= px[54:16];
      st_r[0] <= sq_step(sq_step(seed));
      for (int j = 1; j < STG; j++) st_r[j] <= sq_step(sq_step(st_r[j-1]));
      pad_r[0] <= st_r[STG-1].root;
      for (int j = 1; j < PAD; j++) pad_r[j] <= pad_r[j-1];
    end
  end

  assign root = pad_r[PAD-1];

endmodule

// ===== rtl/obc_cos.sv =====
// Cosine of an inclination in degrees: angle fold, radian scaling and a
// five-step Horner chain in Q30, three stages per step. Uses obc_pkg.
module obc_cos (
  input  logic                    clk,
  input  logic                    en,
  input  logic [obc_pkg::I_W-1:0] ang,
  output logic signed [17:0]      cosv
);
  import obc_pkg::*;

  function automatic logic [31:0] mul_hi30(logic [31:0] a, logic [30:0] b);
    logic [62:0] p;
    p = 63'(a) * 63'(b);
    return p[61:30];
  endfunction

  function automatic logic [31:0] mul_hi32(logic [31:0] a, logic [31:0] b);
    logic [63:0] p;
    p = 64'(a) * 64'(b);
    return p[63:32];
  endfunction

  // estimate is exact or one low; fix it with one compare
  function automatic logic signed [33:0] horner_fix(logic [31:0] y, logic [31:0] qe,
                                                     logic [6:0] dv);
    logic [31:0] rem;
    logic [31:0] qq;
    rem = y - 32'(qe * 32'(dv));
    qq  = qe + 32'(rem >= 32'(dv));
    return $signed(34'(COS_ONE)) - $signed({2'b00, qq});
  endfunction

  logic [16:0] a1, a2;
  logic        neg_nxt;
  logic [14:0] a_r;
  logic        neg1_r, neg2_r, neg3_r;
  logic [30:0] x_r;
  logic [61:0] xx;
  logic [31:0] x2_r;

  logic [31:0]        y_r   [COS_STEPS];
  logic [31:0]        yb_r  [COS_STEPS];
  logic [31:0]        qe_r  [COS_STEPS];
  logic signed [33:0] tv_r  [COS_STEPS];
  logic [31:0]        x2a_r [COS_STEPS];
  logic [31:0]        x2b_r [COS_STEPS];
  logic [31:0]        x2c_r [COS_STEPS];
  logic               nega_r [COS_STEPS];
  logic               negb_r [COS_STEPS];
  logic               negc_r [COS_STEPS];

  logic signed [33:0] cv;
  logic [16:0]        cc;
  logic signed [17:0] cos_r;

  always_comb begin
    // above 180 degrees use 360 minus the angle, above 90 mirror and negate
    a1 = (17'(ang) > ANG_180) ? ANG_360 - 17'(ang) : 17'(ang);
    neg_nxt = (a1 > ANG_90);
    a2 = neg_nxt ? ANG_180 - a1 : a1;
    xx = 62'(x_r) * 62'(x_r);
    cv = tv_r[COS_STEPS-1];
    cc = cv[33] ? '0 : cv[30:14];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r    <= a2[14:0];
      neg1_r <= neg_nxt;
      x_r    <= 31'(31'(a_r) * 31'(DEG2RAD));
      neg2_r <= neg1_r;
      x2_r   <= xx[61:30];
      neg3_r <= neg2_r;
      for (int k = 0; k < COS_STEPS; k++) begin
        if (k == 0) begin
          y_r[k]    <= mul_hi30(x2_r, COS_ONE);
          x2a_r[k]  <= x2_r;
          nega_r[k] <= neg3_r;
        end else begin
          y_r[k]    <= mul_hi30(x2c_r[k-1], tv_r[k-1][30:0]);
          x2a_r[k]  <= x2c_r[k-1];
          nega_r[k] <= negc_r[k-1];
        end
        qe_r[k]   <= mul_hi32(y_r[k], COS_REC[k]);
        yb_r[k]   <= y_r[k];
        x2b_r[k]  <= x2a_r[k];
        negb_r[k] <= nega_r[k];
        tv_r[k]   <= horner_fix(yb_r[k], qe_r[k], COS_DIV[k]);
        x2c_r[k]  <= x2b_r[k];
        negc_r[k] <= negb_r[k];
      end
      cos_r <= negc_r[COS_STEPS-1] ? -$signed({1'b0, cc}) : $signed({1'b0, cc});
    end
  end

  assign cosv = cos_r;

endmodule

// ===== rtl/orbit_bin_and_classify.sv =====
// Top level: orbit binning and class tests, 22-stage pipeline taking one
// orbit per cycle. Uses obc_pkg, obc_classify, obc_recip, obc_isqrt, obc_cos.
//
// One orbit enters per clock; the block sustains one orbit per cycle as
// long as out_stall stays low. The latency is set by the cosine unit's
// five-step Horner chain (three stages per step) that feeds the Tisserand
// test, followed by three combine stages. When a result waits at the
// output under out_stall, the whole pipeline holds and in_stall rises;
// nothing is dropped or repeated.
module orbit_bin_and_classify (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [obc_pkg::Q_W-1:0]        in_perihelion,
  input  logic [obc_pkg::E_W-1:0]        in_eccentricity,
  input  logic [obc_pkg::I_W-1:0]        in_inclination,
  input  logic signed [obc_pkg::H_W-1:0] in_magnitude,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_in_model,
  output logic [4:0]                     out_q_bin,
  output logic [2:0]                     out_e_bin,
  output logic [3:0]                     out_i_bin,
  output logic [4:0]                     out_h_bin,
  output logic [14:0]                    out_class_mask
);
  import obc_pkg::*;

  logic                 adv;
  logic [PIPE_LAT-1:0]  vld_r;
  side_t                side, side1_r, side2_r;
  logic [15:0]          rcp;
  logic [19:0]          sroot;
  logic signed [17:0]   cosv;
  logic [16:0]          ac;
  logic [32:0]          p1_r;
  logic [36:0]          p2_r;
  logic                 cneg1_r;
  logic [51:0]          m1w;
  logic [19:0]          m1;
  logic [21:0]          m2;
  logic signed [23:0]   t1_r, t2_r;
  logic signed [24:0]   tsum;
  logic                 jfc;

  // advance everything unless a result sits at the output and is held
  assign adv      = !vld_r[PIPE_LAT-1] || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_valid};
    end
  end

  obc_classify u_cls (
    .clk  (clk),
    .en   (adv),
    .q    (in_perihelion),
    .e    (in_eccentricity),
    .i    (in_inclination),
    .h    (in_magnitude),
    .side (side)
  );

  obc_recip u_rcp (
    .clk (clk),
    .en  (adv),
    .den (in_perihelion),
    .quo (rcp)
  );

  obc_isqrt u_sqt (
    .clk  (clk),
    .en   (adv),
    .q    (in_perihelion),
    .e    (in_eccentricity),
    .root (sroot)
  );

  obc_cos u_cos (
    .clk  (clk),
    .en   (adv),
    .ang  (in_inclination),
    .cosv (cosv)
  );

  always_comb begin
    ac   = cosv[17] ? 17'(-cosv) : cosv[16:0];
    m1w  = 52'(p1_r) * 52'(JFC_K1);
    m1   = m1w[51:32];
    m2   = p2_r[36:15];
    tsum = 25'(t1_r) + 25'(t2_r);
    jfc  = side2_r.jfc_q_ok && (tsum > $signed(T_LO)) && (tsum < $signed(T_HI));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r    <= 33'(side.ad) * 33'(rcp);
      p2_r    <= 37'(sroot) * 37'(ac);
      cneg1_r <= cosv[17];
      side1_r <= side;
      t1_r    <= side1_r.d_neg ? -$signed(24'(m1)) : $signed(24'(m1));
      t2_r    <= cneg1_r ? -$signed(24'(m2)) : $signed(24'(m2));
      side2_r <= side1_r;
      out_in_model   <= side2_r.in_model;
      out_q_bin      <= side2_r.q_bin;
      out_e_bin      <= side2_r.e_bin;
      out_i_bin      <= side2_r.i_bin;
      out_h_bin      <= side2_r.h_bin;
      out_class_mask <= {jfc, side2_r.mask};
    end
  end

  assign out_valid = vld_r[PIPE_LAT-1];

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for orbit_bin_and_classify: drives orbits through the
// valid/stall channel, predicts bins and class masks, checks every result.
// Depends on obc_pkg (port widths and PIPE_LAT) and the block's RTL.
module tb_top;
  import obc_pkg::*;

  typedef struct {
    bit        in_model;
    bit [4:0]  q_bin;
    bit [2:0]  e_bin;
    bit [3:0]  i_bin;
    bit [4:0]  h_bin;
    bit [14:0] class_mask;
  } orbit_bins_t;

  class orbit_scoreboard;
    orbit_bins_t pending_bins[$];
    int unsigned mismatches;
    int unsigned results_seen;
    bit [14:0]   classes_hit;

    function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned root, b;
      root = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= root + b) begin
          v = v - (root + b);
          root = (root >> 1) + b;
        end else begin
          root >>= 1;
        end
        b >>= 2;
      end
      return root;
    endfunction

    // cos of a Q8.8 degree angle, Q16 signed result
    function automatic longint cos_deg(bit [15:0] ang_raw);
      longint unsigned ang, x, x2, t;
      longint c;
      bit neg;
      int unsigned dv[5] = '{90, 56, 30, 12, 2};
      ang = ang_raw > 46080 ? 92160 - ang_raw : ang_raw;
      neg = 0;
      if (ang > 23040) begin
        ang = 46080 - ang;
        neg = 1;
      end
      x = ang * 64'd73204;
      x2 = (x * x) >> 30;
      t = 64'd1073741824 - x2 / dv[0];
      for (int k = 1; k < 4; k++) t = 64'd1073741824 - ((x2 * t) >> 30) / dv[k];
      c = 64'sd1073741824 - longint'(((x2 * t) >> 30) / dv[4]);
      if (c < 0) c = 0;
      c = c >>> 14;
      return neg ? -c : c;
    endfunction

    function automatic bit aphelion_above(longint unsigned q, longint unsigned e,
                                          longint unsigned lim);
      if (e >= 65536) return 1;
      return q * (65536 + e) > lim * (65536 - e);
    endfunction

    function automatic bit axis_between(longint unsigned q, longint unsigned e,
                                        longint unsigned lo, longint unsigned hi);
      longint unsigned d;
      if (e >= 65536) return 0;
      d = 65536 - e;
      return (q << 16) > lo * d && (q << 16) < hi * d;
    endfunction

    function automatic bit tisserand_comet(longint unsigned q, longint unsigned e,
                                           bit [15:0] incl);
      longint d, t1, t2, c;
      longint unsigned ad, r, m1, x, s, ac, m2;
      if (q < 85197) return 0;
      d = 65536 - longint'(e);
      ad = d < 0 ? -d : d;
      r = (64'd1 << 32) / q;
      m1 = (64'd340787 * ad * r) >> 32;
      t1 = d < 0 ? -longint'(m1) : longint'(m1);
      x = (q * (65536 + e) * 64'd12603) >> 16;
      s = floor_sqrt(x);
      c = cos_deg(incl);
      ac = c < 0 ? -c : c;
      m2 = (64'd2 * s * ac) >> 16;
      t2 = c < 0 ? -longint'(m2) : longint'(m2);
      return t1 + t2 > 131072 && t1 + t2 < 196608;
    endfunction

    function automatic orbit_bins_t classify_orbit(bit [22:0] qr, bit [16:0] er,
                                                   bit [15:0] ir, bit [15:0] hr);
      int unsigned q_edge[29] = '{
        26214, 45875, 52429, 58982, 65536, 72090, 78643, 85197, 91750, 98304,
        109445, 117965, 131072, 144179, 157286, 170394, 183501, 196608, 209715,
        229376, 262144, 294912, 327680, 360448, 655360, 1310720, 1966080,
        2621440, 6553600};
      int unsigned e_edge[8] = '{6554, 13107, 19661, 26214, 32768, 45875, 58982,
                                 72090};
      int unsigned i_edge[11] = '{512, 1280, 2560, 3840, 5120, 6400, 7680, 10240,
                                  15360, 23040, 46080};
      int h_edge[18] = '{1536, 2048, 2560, 2816, 3072, 3328, 3584, 3840, 4096,
                         4352, 4608, 4864, 5120, 5376, 5632, 5888, 6144, 6528};
      orbit_bins_t res;
      longint unsigned q, e, i, d;
      int h, qb, eb, ib, hb;
      bit [14:0] m;
      q = qr; e = er; i = ir;
      h = int'($signed(hr));
      qb = 0; eb = 0; ib = 0; hb = 0;
      while (qb < 29 && q >= q_edge[qb]) qb++;
      while (eb < 8 && e >= e_edge[eb]) eb++;
      while (ib < 11 && i >= i_edge[ib]) ib++;
      while (hb < 17 && h >= h_edge[hb]) hb++;
      res.in_model = qb < 29 && eb < 8 && ib < 11;
      if (!res.in_model) begin
        qb = 0; eb = 0; ib = 0; hb = 0;
      end
      d = e < 65536 ? 65536 - e : 0;
      m = '0;
      m[0] = q < 85197 || e >= 32768 || i >= 10240 || aphelion_above(q, e, 655360);
      m[1] = q < 85197;
      m[2] = q < 85197 && h < 5760;
      m[3] = q < 85197 && h < 4736;
      m[4] = q < 109445 && q >= 85197 && aphelion_above(q, e, 103547);
      m[5] = !(e > 11796 || i < 4096 || i > 8704) &&
             axis_between(q, e, 116654, 131072);
      m[6] = !(q < 98304 || i < 5120 || i > 6912) &&
             axis_between(q, e, 144179, 160563);
      m[7] = q >= 109445 && axis_between(q, e, 137626, 163840) &&
             i * d + 64'd11648 * d < 64'd6400 * q;
      m[8] = !(e > 22938 || i < 6144 || i > 9472) &&
             axis_between(q, e, 163840, 183501);
      m[9] = !(e > 16384 || i < 5120 || i > 6016) &&
             axis_between(q, e, 167117, 178258);
      m[10] = !(e > 29491 || i > 5120) && axis_between(q, e, 163840, 183501);
      m[11] = !(e > 26214) && axis_between(q, e, 183501, 212992) &&
              64'd9 * i * d + 64'd183296 * d < 64'd81920 * q;
      m[12] = !(i > 4608 || e > 26214) && axis_between(q, e, 255590, 263455);
      m[13] = !(e > 14418 || i > 9728) && axis_between(q, e, 330957, 350618);
      m[14] = tisserand_comet(q, e, ir);
      res.q_bin = qb;
      res.e_bin = eb;
      res.i_bin = ib;
      res.h_bin = hb;
      res.class_mask = m;
      return res;
    endfunction

    function void note_orbit(bit [22:0] q, bit [16:0] e, bit [15:0] i, bit [15:0] h);
      pending_bins.push_back(classify_orbit(q, e, i, h));
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatches++;
    endtask

    task check_result(orbit_bins_t got);
      orbit_bins_t want;
      results_seen++;
      if (pending_bins.size() == 0) begin
        report_mismatch("unexpected transfer, class_mask", got.class_mask, -1);
        return;
      end
      want = pending_bins.pop_front();
      classes_hit |= want.class_mask;
      if (got.in_model != want.in_model) report_mismatch("in_model", got.in_model, want.in_model);
      if (got.q_bin != want.q_bin) report_mismatch("q_bin", got.q_bin, want.q_bin);
      if (got.e_bin != want.e_bin) report_mismatch("e_bin", got.e_bin, want.e_bin);
      if (got.i_bin != want.i_bin) report_mismatch("i_bin", got.i_bin, want.i_bin);
      if (got.h_bin != want.h_bin) report_mismatch("h_bin", got.h_bin, want.h_bin);
      if (got.class_mask != want.class_mask)
        report_mismatch("class_mask", got.class_mask, want.class_mask);
    endtask
  endclass

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_stall;
  logic [Q_W-1:0]  in_perihelion;
  logic [E_W-1:0]  in_eccentricity;
  logic [I_W-1:0]  in_inclination;
  logic [H_W-1:0]  in_magnitude;
  logic            out_valid;
  logic            out_stall;
  logic            out_in_model;
  logic [4:0]      out_q_bin;
  logic [2:0]      out_e_bin;
  logic [3:0]      out_i_bin;
  logic [4:0]      out_h_bin;
  logic [14:0]     out_class_mask;

  orbit_scoreboard sb;
  int unsigned orbits_sent;
  int unsigned quiet_cycles;
  int unsigned stall_hold;
  bit          steady;

  localparam int QUIET_LIMIT = 5000;

  orbit_bin_and_classify dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver side: stall runs of random length
  always @(posedge clk) begin
    if (!rst_n || steady) begin
      out_stall <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
      stall_hold <= pick_gap();
    end
  end

  // sample at the falling edge: values are settled and hold through the next rising edge
  always @(negedge clk) begin
    orbit_bins_t got;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.in_model = out_in_model;
        got.q_bin = out_q_bin;
        got.e_bin = out_e_bin;
        got.i_bin = out_i_bin;
        got.h_bin = out_h_bin;
        got.class_mask = out_class_mask;
        sb.check_result(got);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task send_orbit(bit [22:0] q, bit [16:0] e, bit [15:0] i, bit [15:0] h);
    int unsigned gap;
    gap = pick_gap();
    @(posedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_perihelion <= q;
    in_eccentricity <= e;
    in_inclination <= i;
    in_magnitude <= h;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    sb.note_orbit(q, e, i, h);
    orbits_sent++;
  endtask

  // orbit drawn from a semi-major axis so the belt and resonance tests get hit
  task send_belt_orbit();
    longint unsigned a, e, q;
    a = $urandom_range(65536, 380000);
    e = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 70000) : $urandom_range(0, 30000);
    q = e < 65536 ? (a * (65536 - e)) >> 16 : $urandom_range(0, 400000);
    send_orbit(q, e, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 46080)
                                                 : $urandom_range(0, 12000),
               ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 8000));
  endtask

  task drain();
    @(posedge clk);
    in_valid <= 1'b0;
    while (sb.pending_bins.size() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_perihelion = '0;
    in_eccentricity = '0;
    in_inclination = '0;
    in_magnitude = '0;
    out_stall = 1'b0;
    steady = 1'b0;
    orbits_sent = 0;
    quiet_cycles = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // extremes, bin edges, special cases, and orbits for most of the classes
    send_orbit(0, 0, 0, 16'h8000);
    send_orbit(23'h7fffff, 17'h1ffff, 16'hffff, 16'h7fff);
    send_orbit(6553599, 72089, 46079, 6527);
    send_orbit(6553600, 0, 0, 6528);
    send_orbit(100000, 72090, 0, 6144);
    send_orbit(100000, 0, 46080, 1535);
    send_orbit(85196, 0, 0, 5759);
    send_orbit(85197, 0, 0, 4735);
    send_orbit(80000, 30000, 2000, 5000);
    send_orbit(120000, 65536, 2000, 3000);
    send_orbit(120000, 131071, 2000, 3000);
    send_orbit(200000, 10000, 50000, 3000);
    send_orbit(112066, 6554, 5120, 4000);
    send_orbit(98304, 39322, 2560, 4000);
    send_orbit(98304, 39322, 44000, 4000);
    send_orbit(323748, 3277, 2560, 3000);
    send_orbit(208143, 13107, 1280, 3000);
    send_orbit(135660, 6554, 1280, 3000);
    send_orbit(176947, 6554, 1280, 3000);
    send_orbit(159252, 6554, 1280, 3000);
    send_orbit(145228, 13107, 8000, 3000);
    send_orbit(98304, 13107, 1280, 3000);
    send_orbit(123732, 13107, 6000, 3000);
    drain();

    for (int n = 0; n < 1400; n++) begin
      if (n == 300) steady = 1'b1;
      if (n == 450) steady = 1'b0;
      if (n == 700) drain();
      if ($urandom_range(0, 4) == 0)
        send_orbit($urandom, $urandom, $urandom, $urandom);
      else
        send_belt_orbit();
    end
    drain();
    repeat (PIPE_LAT + 10) @(posedge clk);

    $display("orbits sent %0d, results checked %0d, class tests exercised mask %h",
             orbits_sent, sb.results_seen, sb.classes_hit);
    if (sb.mismatches == 0 && sb.pending_bins.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches,
               sb.pending_bins.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/obc_pkg.sv
rtl/obc_classify.sv
rtl/obc_recip.sv
rtl/obc_isqrt.sv
rtl/obc_cos.sv
rtl/orbit_bin_and_classify.sv
tb/tb_top.sv
